// File: hw/rtl/tod_pkg.sv
// Shared types, command codes and constants of the time-of-day counter.
package tod_pkg;

  // Command codes carried in the command field of an input beat.
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_ADVANCE = 2'd1;
  localparam logic [1:0] CMD_RETARD  = 2'd2;

  // Field widths.
  localparam int unsigned CmdW    = 2;
  localparam int unsigned AmountW = 8;
  localparam int unsigned SecW    = 6;
  localparam int unsigned MinW    = 6;
  localparam int unsigned HourW   = 5;
  localparam int unsigned DayW    = 16;
  localparam int unsigned TickW   = 8;

  // Time constants and reset values.
  localparam logic [SecW:0]    SecPerMin    = 7'd60;
  localparam logic [MinW:0]    MinPerHour   = 7'd60;
  localparam logic [HourW-1:0] LastHour     = 5'd23;
  localparam logic [TickW-1:0] TicksReset   = 8'd61;
  localparam logic [DayW-1:0]  DayReset     = 16'd21;

  typedef struct packed {
    logic [CmdW-1:0]    command;
    logic [AmountW-1:0] amount;
  } tod_in_t;

  typedef struct packed {
    logic [SecW-1:0]  seconds_now;
    logic [MinW-1:0]  minutes_now;
    logic [HourW-1:0] hours_now;
    logic signed [DayW-1:0] day_count;
    logic             second_changed;
    logic             colon_on;
  } tod_out_t;

  // Running time of day held between the top level and the update logic.
  typedef struct packed {
    logic [SecW-1:0]  sec;
    logic [MinW-1:0]  min;
    logic [HourW-1:0] hour;
    logic [DayW-1:0]  day;
  } tod_time_t;

endpackage

// File: hw/rtl/time_of_day_counter.sv
// Top level of the time-of-day counter: input register, time state and result register.
// The counter takes one command beat per clock cycle while the result register is free
// or being emptied, and presents one result beat for each: the beat waits in the input
// register and then passes through the carry and borrow logic into the result register.
// Tick beats count the prescaler up to ticks_per_second and then advance one second;
// advance and retard beats move the time by 0 to 255 seconds, wrapping the day count
// across midnight. The result holds the time, a flag that the seconds differ from the
// last result, and a colon flag that is on in even seconds. ticks_per_second resets to
// 61 and is written with cfg_we_i; write it only while no beat is in flight.
module time_of_day_counter import tod_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tod_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tod_out_t         out_data_o,
  input  logic             cfg_we_i,
  input  logic [TickW-1:0] cfg_wdata_i
);

  logic             in_valid_q;
  tod_in_t          in_q;
  logic             out_valid_q;
  tod_out_t         out_q;
  logic [TickW-1:0] tps_q;
  logic [TickW-1:0] tick_q;
  logic [TickW-1:0] tick_d;
  tod_time_t        time_q;
  tod_time_t        time_d;
  logic             rep_valid_q;
  logic [SecW-1:0]  rep_sec_q;
  logic             advance;
  logic             fire;

  // The pipeline moves whenever the result register is free or being emptied.
  assign advance     = !out_valid_q || out_ready_i;
  assign fire        = in_valid_q && advance;
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Prescaler limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TicksReset;
    end else if (cfg_we_i) begin
      tps_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  tod_update u_update (
    .item_i             (in_q),
    .ticks_per_second_i (tps_q),
    .tick_i             (tick_q),
    .time_i             (time_q),
    .tick_o             (tick_d),
    .time_o             (time_d)
  );

  // Time state and the record of the last reported seconds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      time_q.sec  <= '0;
      time_q.min  <= '0;
      time_q.hour <= '0;
      time_q.day  <= DayReset;
      rep_valid_q <= 1'b0;
      rep_sec_q   <= '0;
    end else if (fire) begin
      tick_q      <= tick_d;
      time_q      <= time_d;
      rep_valid_q <= 1'b1;
      rep_sec_q   <= time_d.sec;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.seconds_now    <= time_d.sec;
      out_q.minutes_now    <= time_d.min;
      out_q.hours_now      <= time_d.hour;
      out_q.day_count      <= time_d.day;
      out_q.second_changed <= !rep_valid_q || (time_d.sec != rep_sec_q);
      out_q.colon_on       <= !time_d.sec[0];
    end
  end

`ifndef ASSERT_OFF
  // A shown result always carries a legal time of day.
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.seconds_now < 6'd60) && (out_data_o.minutes_now < 6'd60)
      && (out_data_o.hours_now < 5'd24))
    else $error("result time out of range");

  // The colon flag follows the parity of the seconds.
  a_colon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.colon_on == !out_data_o.seconds_now[0]))
    else $error("colon flag does not match seconds");

  // The result beat reports the state that the update just stored.
  a_result_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q && (out_q.seconds_now == time_q.sec)
      && (out_q.day_count == time_q.day))
    else $error("result differs from stored time");

  // Unchanged seconds after an earlier report must not raise the change flag.
  a_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && rep_valid_q && (time_d.sec == rep_sec_q) |=> !out_q.second_changed)
    else $error("change flag raised without a change");
`endif

endmodule

// File: hw/rtl/tod_update.sv
// Single-pass next-state logic: prescaler, seconds adjust with carry and borrow.
module tod_update import tod_pkg::*; (
  input  tod_in_t          item_i,
  input  logic [TickW-1:0] ticks_per_second_i,
  input  logic [TickW-1:0] tick_i,
  input  tod_time_t        time_i,
  output logic [TickW-1:0] tick_o,
  output tod_time_t        time_o
);

  logic [AmountW-1:0] adj;
  logic               add_en;
  logic               sub_en;
  logic [TickW:0]     tick_next;
  logic [2:0]         adj_min;
  logic [SecW-1:0]    adj_sec;
  logic [SecW:0]      sum_s;
  logic [MinW:0]      sum_m;
  logic               carry_s;
  logic               carry_m;
  logic [SecW:0]      dif_s;
  logic [MinW:0]      dif_m;
  logic               borrow_s;
  logic               borrow_m;
  logic [SecW:0]      sec_fix;
  logic [MinW:0]      min_fix;
  logic [SecW:0]      sec_wrap;
  logic [MinW:0]      min_wrap;
  tod_time_t          t_add;
  tod_time_t          t_sub;

  // Decode the command; a prescaler wrap becomes a one-second advance.
  always_comb begin
    adj       = item_i.amount;
    add_en    = 1'b0;
    sub_en    = 1'b0;
    tick_o    = tick_i;
    tick_next = {1'b0, tick_i} + {{TickW{1'b0}}, 1'b1};
    case (item_i.command)
      CMD_TICK: begin
        if (tick_next >= {1'b0, ticks_per_second_i}) begin
          tick_o = '0;
          add_en = 1'b1;
          adj    = 8'd1;
        end else begin
          tick_o = tick_next[TickW-1:0];
        end
      end
      CMD_ADVANCE: add_en = 1'b1;
      CMD_RETARD:  sub_en = 1'b1;
      default: ;
    endcase
  end

  // Split the adjustment into whole minutes and leftover seconds.
  always_comb begin
    if (adj >= 8'd240) begin
      adj_min = 3'd4;
      adj_sec = 6'(adj - 8'd240);
    end else if (adj >= 8'd180) begin
      adj_min = 3'd3;
      adj_sec = 6'(adj - 8'd180);
    end else if (adj >= 8'd120) begin
      adj_min = 3'd2;
      adj_sec = 6'(adj - 8'd120);
    end else if (adj >= 8'd60) begin
      adj_min = 3'd1;
      adj_sec = 6'(adj - 8'd60);
    end else begin
      adj_min = 3'd0;
      adj_sec = adj[SecW-1:0];
    end
  end

  // Forward path: carry seconds into minutes, minutes into hours and days.
  always_comb begin
    t_add   = time_i;
    sum_s   = {1'b0, time_i.sec} + {1'b0, adj_sec};
    carry_s = (sum_s >= SecPerMin);
    sec_fix = carry_s ? sum_s - SecPerMin : sum_s;
    t_add.sec = sec_fix[SecW-1:0];
    sum_m   = {1'b0, time_i.min} + {4'b0, adj_min} + {{MinW{1'b0}}, carry_s};
    carry_m = (sum_m >= MinPerHour);
    min_fix = carry_m ? sum_m - MinPerHour : sum_m;
    t_add.min = min_fix[MinW-1:0];
    if (carry_m) begin
      if (time_i.hour == LastHour) begin
        t_add.hour = '0;
        t_add.day  = time_i.day + 16'd1;
      end else begin
        t_add.hour = time_i.hour + 5'd1;
      end
    end
  end

  // Backward path: borrow from minutes and hours; hour zero wraps to the last hour.
  always_comb begin
    t_sub    = time_i;
    dif_s    = {1'b0, time_i.sec} - {1'b0, adj_sec};
    borrow_s = dif_s[SecW];
    sec_wrap = borrow_s ? dif_s + SecPerMin : dif_s;
    t_sub.sec = sec_wrap[SecW-1:0];
    dif_m    = {1'b0, time_i.min} - {4'b0, adj_min} - {{MinW{1'b0}}, borrow_s};
    borrow_m = dif_m[MinW];
    min_wrap = borrow_m ? dif_m + MinPerHour : dif_m;
    t_sub.min = min_wrap[MinW-1:0];
    if (borrow_m) begin
      if (time_i.hour == '0) begin
        t_sub.hour = LastHour;
        t_sub.day  = time_i.day - 16'd1;
      end else begin
        t_sub.hour = time_i.hour - 5'd1;
      end
    end
  end

  // Pick the path that the command asked for.
  always_comb begin
    if (add_en) begin
      time_o = t_add;
    end else if (sub_en) begin
      time_o = t_sub;
    end else begin
      time_o = time_i;
    end
  end

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the time-of-day counter with random handshake pressure.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tod_pkg::*;

  // Command code that the block leaves undefined; it must change no time state.
  localparam logic [CmdW-1:0] CmdSpare = 2'd3;
  localparam int unsigned SecsPerDay = 86400;
  localparam int unsigned PhaseBeats = 290;
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned HoldOffStart = 1000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles = 4;

  // Predicts each result beat and checks the beats the block returns.
  class tod_tracker;
    logic [TickW-1:0] ticks_per_sec;
    logic [TickW-1:0] tick_cnt;
    int unsigned      day_secs;
    logic [DayW-1:0]  day_num;
    logic [7:0]       last_sec;
    tod_out_t         reports_due[$];
    int               errors;

    function new();
      ticks_per_sec = TicksReset;
      tick_cnt      = '0;
      day_secs      = 0;
      day_num       = DayReset;
      last_sec      = 8'd200;
      errors        = 0;
    endfunction

    function void move_forward(int unsigned n);
      day_secs += n;
      if (day_secs >= SecsPerDay) begin
        day_secs -= SecsPerDay;
        day_num++;
      end
    endfunction

    function void move_back(int unsigned n);
      if (day_secs < n) begin
        day_secs = day_secs + SecsPerDay - n;
        day_num--;
      end else begin
        day_secs -= n;
      end
    endfunction

    // Apply one accepted command beat and queue the result it must produce.
    function void note_command(tod_in_t beat);
      tod_out_t    want;
      int unsigned sec;
      case (beat.command)
        CMD_TICK: begin
          // A limit of zero behaves like a limit of one.
          if (int'(tick_cnt) + 1 >= int'(ticks_per_sec)) begin
            tick_cnt = '0;
            move_forward(1);
          end else begin
            tick_cnt++;
          end
        end
        CMD_ADVANCE: move_forward(beat.amount);
        CMD_RETARD:  move_back(beat.amount);
        default: ;
      endcase
      sec = day_secs % 60;
      want.seconds_now    = SecW'(sec);
      want.minutes_now    = MinW'((day_secs / 60) % 60);
      want.hours_now      = HourW'(day_secs / 3600);
      want.day_count      = day_num;
      want.second_changed = (8'(sec) != last_sec);
      want.colon_on       = (sec % 2 == 0);
      if (want.second_changed) begin
        last_sec = 8'(sec);
      end
      reports_due.push_back(want);
    endfunction

    function void check_field(string field, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    // Compare one returned beat with the oldest pending prediction.
    function void check_report(tod_out_t got);
      tod_out_t want;
      if (reports_due.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, actual %p", $time, got);
        return;
      end
      want = reports_due.pop_front();
      check_field("seconds_now", want.seconds_now, got.seconds_now);
      check_field("minutes_now", want.minutes_now, got.minutes_now);
      check_field("hours_now", want.hours_now, got.hours_now);
      check_field("day_count", $signed(want.day_count), $signed(got.day_count));
      check_field("second_changed", want.second_changed, got.second_changed);
      check_field("colon_on", want.colon_on, got.colon_on);
    endfunction

    function int pending();
      return reports_due.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  logic             in_ready;
  tod_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  tod_out_t         out_data;
  logic             cfg_we;
  logic [TickW-1:0] cfg_wdata;

  tod_tracker  tracker = new();
  bit          steady;
  int unsigned results_seen;
  int unsigned cycles;

  time_of_day_counter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Free-running 10 ns clock.
  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // Run limit in case the block hangs.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Input beats are predicted as they are accepted.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) begin
      tracker.note_command(in_data);
    end
  end

  // Output beats are checked as they are accepted.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      tracker.check_report(out_data);
      results_seen++;
    end
  end

  // Receiver: random stalls, none while steady, and one long hold-off.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HoldOffStart) begin
        hold_done = 1'b1;
        hold_left = HoldOffCycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 7);
      end
    end
  end

  function automatic tod_in_t make_beat(logic [CmdW-1:0] cmd, logic [AmountW-1:0] amt);
    tod_in_t b;
    b.command = cmd;
    b.amount  = amt;
    return b;
  endfunction

  // Random command; drift phases mostly advance by large steps to sweep the day.
  function automatic tod_in_t random_command(bit drift);
    int      pick;
    tod_in_t b;
    pick     = $urandom_range(0, 99);
    b.amount = AmountW'($urandom_range(0, 255));
    if (drift) begin
      if (pick < 35) begin
        b.command = CMD_TICK;
      end else if (pick < 92) begin
        b.command = CMD_ADVANCE;
        b.amount  = AmountW'($urandom_range(160, 255));
      end else if (pick < 97) begin
        b.command = CMD_RETARD;
      end else begin
        b.command = CmdSpare;
      end
    end else begin
      if (pick < 40) begin
        b.command = CMD_TICK;
      end else if (pick < 68) begin
        b.command = CMD_ADVANCE;
      end else if (pick < 96) begin
        b.command = CMD_RETARD;
      end else begin
        b.command = CmdSpare;
      end
    end
    return b;
  endfunction

  // Offer one beat from a falling edge and hold it until accepted.
  task automatic send_beat(input tod_in_t beat);
    in_valid <= 1'b1;
    in_data  <= beat;
    forever begin
      @(posedge clk_i);
      if (in_ready) break;
    end
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 3)) @(negedge clk_i);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (tracker.pending() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_ticks(input logic [TickW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    tracker.ticks_per_sec = value;
  endtask

  // Stimulus: directed corners at the reset limit, then random phases.
  initial begin
    logic [TickW-1:0] limits[6];
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    steady       = 1'b0;
    results_seen = 0;
    limits       = '{8'd0, 8'd1, 8'd255, 8'd2, 8'd0, TicksReset};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Ticks ignore the amount, the spare code leaves the time alone, zero adjusts do
    // nothing, and retard/advance by one cross midnight in both directions.
    send_beat(make_beat(CMD_TICK, 8'd0));
    send_beat(make_beat(CMD_TICK, 8'd255));
    send_beat(make_beat(CmdSpare, 8'd255));
    send_beat(make_beat(CmdSpare, 8'd0));
    send_beat(make_beat(CMD_ADVANCE, 8'd0));
    send_beat(make_beat(CMD_RETARD, 8'd0));
    send_beat(make_beat(CMD_RETARD, 8'd1));
    send_beat(make_beat(CMD_ADVANCE, 8'd1));
    send_beat(make_beat(CMD_ADVANCE, 8'd255));
    send_beat(make_beat(CMD_ADVANCE, 8'd170));
    send_beat(make_beat(CMD_ADVANCE, 8'd85));
    send_beat(make_beat(CMD_RETARD, 8'd85));
    send_beat(make_beat(CMD_RETARD, 8'd170));
    send_beat(make_beat(CMD_RETARD, 8'd255));
    // Large steps across midnight backward and then forward again.
    send_beat(make_beat(CMD_RETARD, 8'd255));
    send_beat(make_beat(CMD_ADVANCE, 8'd255));
    send_beat(make_beat(CMD_ADVANCE, 8'd59));
    send_beat(make_beat(CMD_ADVANCE, 8'd1));
    send_beat(make_beat(CMD_RETARD, 8'd60));
    send_beat(make_beat(CMD_TICK, 8'd170));
    send_beat(make_beat(CMD_TICK, 8'd85));

    // Each phase starts idle with a new prescaler limit, extremes included.
    for (int p = 0; p < 6; p++) begin
      drain();
      write_ticks((p == 4) ? TickW'($urandom_range(3, 254)) : limits[p]);
      steady = (p == 1);
      repeat (PhaseBeats) begin
        if (!steady && $urandom_range(0, 99) < 7) begin
          idle_gap();
        end
        send_beat(random_command(p % 2 == 0));
      end
    end
    drain();

    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
